// ===== src/ptd_pkg.sv =====
// ptd_pkg: types, reciprocal table and range constants for the perspective texture divide
// no dependencies; used by src/perspective_texture_divide.sv

package ptd_pkg;

   // input transaction payload
   typedef struct packed {
      logic signed [15:0] coordinate;
      logic signed [15:0] w;
   } ptd_req_type;

   // result transaction payload
   typedef struct packed {
      logic signed [16:0] wide_value;
      logic signed [15:0] clamped_value;
      logic               overflow;
   } ptd_rsp_type;

   // reciprocal table size and index width
   localparam int RecipDepth = 65;
   localparam int RecipIdxW  = $clog2(RecipDepth);

   // unsigned q.14 reciprocals of 1.0 .. 2.0 in 64 steps
   localparam logic [14:0] RECIP_ROM [RecipDepth] = '{
      15'h4000, 15'h3f04, 15'h3e10, 15'h3d22, 15'h3c3c, 15'h3b5d, 15'h3a83, 15'h39b1,
      15'h38e4, 15'h381c, 15'h375a, 15'h369d, 15'h35e5, 15'h3532, 15'h3483, 15'h33d9,
      15'h3333, 15'h3291, 15'h31f4, 15'h3159, 15'h30c3, 15'h3030, 15'h2fa1, 15'h2f15,
      15'h2e8c, 15'h2e06, 15'h2d83, 15'h2d03, 15'h2c86, 15'h2c0b, 15'h2b93, 15'h2b1e,
      15'h2aab, 15'h2a3a, 15'h29cc, 15'h2960, 15'h28f6, 15'h288e, 15'h2828, 15'h27c4,
      15'h2762, 15'h2702, 15'h26a4, 15'h2648, 15'h25ed, 15'h2594, 15'h253d, 15'h24e7,
      15'h2492, 15'h243f, 15'h23ee, 15'h239e, 15'h234f, 15'h2302, 15'h22b6, 15'h226c,
      15'h2222, 15'h21da, 15'h2193, 15'h214d, 15'h2108, 15'h20c5, 15'h2082, 15'h2041,
      15'h2000
   };

   // normalisation amount that means w == 1 (product is doubled)
   localparam logic [3:0] SHIFT_MAX = 4'd14;

   // wide clamp bounds on the shifted product
   localparam logic signed [31:0] WIDE_HI = 32'sd65535;
   localparam logic signed [31:0] WIDE_LO = -32'sd65536;

   // 17-bit results
   localparam logic signed [16:0] WIDE_HI_17 = 17'sh0ffff;
   localparam logic signed [16:0] WIDE_LO_17 = 17'sh10000;
   localparam logic signed [16:0] SAT_POS_17 = 17'sh07fff;
   localparam logic signed [16:0] SAT_NEG_17 = 17'sh18000;

   // 16-bit clamp bounds
   localparam logic signed [16:0] NARROW_HI = 17'sd32767;
   localparam logic signed [16:0] NARROW_LO = -17'sd32768;
   localparam logic signed [15:0] SAT_POS_16 = 16'sh7fff;
   localparam logic signed [15:0] SAT_NEG_16 = 16'sh8000;

endpackage

// ===== src/perspective_texture_divide.sv =====
// perspective_texture_divide: five-stage pipelined divide of a texture coordinate by w
// depends on src/ptd_pkg.sv (payload types, reciprocal table, clamp constants)

// Takes one transaction per clock while rsp_ready stays high. The pipeline
// has five register stages: w normalisation, reciprocal table read, linear
// interpolation, the 16x16 multiply, and the final shift, range check and
// clamp into the result register. All stages move together: when the
// result register is full and rsp_ready is low, req_ready drops and every
// stage holds, so nothing is lost or repeated. A non-positive w gives 0x7fff
// with overflow set.

module perspective_texture_divide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ptd_pkg::ptd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ptd_pkg::ptd_rsp_type rsp_data
);

   // pipeline advance
   logic advance;

   // stage 1: normalisation
   logic               st1_valid_ff;
   logic signed [15:0] st1_coord_ff;
   logic               st1_nonpos_ff;
   logic [3:0]         st1_shift_ff;
   logic [5:0]         st1_idx_ff;
   logic [7:0]         st1_frac_ff;
   logic [3:0]         st1_shift_in;
   logic [14:0]        st1_norm;

   // stage 2: table read
   logic               st2_valid_ff;
   logic signed [15:0] st2_coord_ff;
   logic               st2_nonpos_ff;
   logic [3:0]         st2_shift_ff;
   logic [7:0]         st2_frac_ff;
   logic [14:0]        st2_base_ff;
   logic [7:0]         st2_drop_ff;
   logic [14:0]        st2_base_in;
   logic [14:0]        st2_next;
   logic [ptd_pkg::RecipIdxW-1:0] st2_addr0;
   logic [ptd_pkg::RecipIdxW-1:0] st2_addr1;

   // stage 3: interpolation
   logic               st3_valid_ff;
   logic signed [15:0] st3_coord_ff;
   logic               st3_nonpos_ff;
   logic [3:0]         st3_shift_ff;
   logic [14:0]        st3_recip_ff;
   logic [16:0]        st3_step;
   logic [14:0]        st3_recip_in;

   // stage 4: multiply
   logic               st4_valid_ff;
   logic               st4_nonpos_ff;
   logic [3:0]         st4_shift_ff;
   logic signed [30:0] st4_product_ff;
   logic signed [31:0] st4_full;

   // stage 5: shift, range check, clamp
   logic                 rsp_valid_ff;
   ptd_pkg::ptd_rsp_type rsp_data_ff;
   ptd_pkg::ptd_rsp_type rsp_data_in;
   logic signed [31:0]   st5_prod;
   logic signed [31:0]   st5_div;
   logic [29:0]          st5_mask;
   logic [29:0]          st5_outside;
   logic                 st5_pick;

   // whole pipeline moves when the result register can be emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         rsp_valid_ff <= st4_valid_ff;
      end
   end

   // stage 1: leading one search puts the top bit of w on bit 14
   always_comb begin
      st1_shift_in = ptd_pkg::SHIFT_MAX;
      for (int i = 0; i < 15; i++) begin
         if (req_data.w[i]) begin
            st1_shift_in = 4'(14 - i);
         end
      end
      st1_norm = req_data.w[14:0] << st1_shift_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_coord_ff  <= req_data.coordinate;
         st1_nonpos_ff <= req_data.w[15] || (req_data.w == 16'sd0);
         st1_shift_ff  <= st1_shift_in;
         st1_idx_ff    <= st1_norm[13:8];
         st1_frac_ff   <= st1_norm[7:0];
      end
   end

   // stage 2: neighbouring table entries and their difference
   always_comb begin
      st2_addr0   = {1'b0, st1_idx_ff};
      st2_addr1   = st2_addr0 + 7'd1;
      st2_base_in = ptd_pkg::RECIP_ROM[st2_addr0];
      st2_next    = ptd_pkg::RECIP_ROM[st2_addr1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st2_coord_ff  <= st1_coord_ff;
         st2_nonpos_ff <= st1_nonpos_ff;
         st2_shift_ff  <= st1_shift_ff;
         st2_frac_ff   <= st1_frac_ff;
         st2_base_ff   <= st2_base_in;
         st2_drop_ff   <= 8'(st2_base_in - st2_next);
      end
   end

   // stage 3: reciprocal minus the rounded-up interpolation step
   always_comb begin
      st3_step     = 17'({8'd0, st2_drop_ff} * {8'd0, st2_frac_ff}) + 17'd255;
      st3_recip_in = st2_base_ff - 15'(st3_step[16:8]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st3_coord_ff  <= st2_coord_ff;
         st3_nonpos_ff <= st2_nonpos_ff;
         st3_shift_ff  <= st2_shift_ff;
         st3_recip_ff  <= st3_recip_in;
      end
   end

   // stage 4: signed coordinate times unsigned reciprocal
   assign st4_full = st3_coord_ff * $signed({1'b0, st3_recip_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         st4_nonpos_ff  <= st3_nonpos_ff;
         st4_shift_ff   <= st3_shift_ff;
         st4_product_ff <= st4_full[30:0];
      end
   end

   // stage 5: denormalise, check the guard bits, then saturate or clamp
   always_comb begin
      st5_prod = {st4_product_ff[30], st4_product_ff};
      if (st4_shift_ff == ptd_pkg::SHIFT_MAX) begin
         st5_div  = st5_prod <<< 1;
         st5_pick = st5_prod[29];
      end else begin
         st5_div  = st5_prod >>> (4'd13 - st4_shift_ff);
         st5_pick = st5_div[29];
      end
      // guard bits run from 29 - shift up to bit 29
      st5_mask    = 30'h3fffffff << (5'd29 - {1'b0, st4_shift_ff});
      st5_outside = st4_product_ff[29:0] & st5_mask;

      rsp_data_in.overflow = 1'b0;
      if (st4_nonpos_ff) begin
         rsp_data_in.overflow   = 1'b1;
         rsp_data_in.wide_value = ptd_pkg::SAT_POS_17;
      end else if ((st5_outside != 30'd0) && (st5_outside != st5_mask)) begin
         rsp_data_in.overflow   = 1'b1;
         rsp_data_in.wide_value = st5_pick ? ptd_pkg::SAT_NEG_17 : ptd_pkg::SAT_POS_17;
      end else if (st5_div > ptd_pkg::WIDE_HI) begin
         rsp_data_in.wide_value = ptd_pkg::WIDE_HI_17;
      end else if (st5_div < ptd_pkg::WIDE_LO) begin
         rsp_data_in.wide_value = ptd_pkg::WIDE_LO_17;
      end else begin
         rsp_data_in.wide_value = st5_div[16:0];
      end

      // narrow copy clamped to 16 bits
      if (rsp_data_in.wide_value > ptd_pkg::NARROW_HI) begin
         rsp_data_in.clamped_value = ptd_pkg::SAT_POS_16;
      end else if (rsp_data_in.wide_value < ptd_pkg::NARROW_LO) begin
         rsp_data_in.clamped_value = ptd_pkg::SAT_NEG_16;
      end else begin
         rsp_data_in.clamped_value = rsp_data_in.wide_value[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an overflow always carries one of the two saturation values
   a_ovf_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         (rsp_data.wide_value == ptd_pkg::SAT_POS_17) ||
         (rsp_data.wide_value == ptd_pkg::SAT_NEG_17))
      else $error("overflow result not saturated");

   // narrow value equals wide value whenever the wide value fits 16 bits
   a_narrow_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.wide_value <= ptd_pkg::NARROW_HI) &&
         (rsp_data.wide_value >= ptd_pkg::NARROW_LO) |->
         rsp_data.clamped_value == rsp_data.wide_value[15:0])
      else $error("clamped value disagrees with wide value");

   // a transaction in the multiply stage reaches the result register when the pipe moves
   a_last_stage : assert property (@(posedge clock) disable iff (reset)
      st4_valid_ff && advance |=> rsp_valid_ff)
      else $error("transaction dropped before result register");

   // a held result keeps the pipe frozen
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(st4_product_ff) && rsp_valid)
      else $error("pipeline moved while result stalled");

endmodule

// ===== verif/perspective_texture_divide_tb.sv =====
// perspective_texture_divide_tb: self-checking bench for the perspective texture divide
// depends on src/ptd_pkg.sv and src/perspective_texture_divide.sv; predicts each quotient,
// drives bursty valid/ready traffic with a stalling receiver and checks every field

module perspective_texture_divide_tb;

   localparam int NumRandom      = 1200;
   localparam int DrainEvery     = 300;
   localparam int WatchdogLimit  = 4000;
   localparam int TailCycles     = 12;
   localparam int MaxPrinted     = 40;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ptd_pkg::ptd_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ptd_pkg::ptd_rsp_type rsp_data;

   // inputs waiting to be sent and quotients waiting to come back
   ptd_pkg::ptd_req_type coord_w_q[$];
   ptd_pkg::ptd_rsp_type quotient_q[$];

   int           sent_count    = 0;
   int           checked_count = 0;
   int           fail_count    = 0;
   int           burst_left    = 0;
   int           gap_left      = 0;
   int           rx_cycle      = 0;
   int           stall_cycles  = 0;

   perspective_texture_divide dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // bit-exact quotient of coordinate over w via the interpolated reciprocal
   function automatic ptd_pkg::ptd_rsp_type divide_by_w(ptd_pkg::ptd_req_type item);
      ptd_pkg::ptd_rsp_type res;
      longint signed   coord;
      longint signed   w_val;
      longint signed   r_lo;
      longint signed   r_hi;
      longint signed   recip;
      longint signed   product;
      longint signed   divided;
      longint signed   pick;
      longint signed   wide;
      longint signed   narrow;
      int unsigned     w_u;
      int unsigned     norm;
      int              bw;
      int              shift;
      int              idx;
      int              frac;
      logic [31:0]     mask;
      logic [31:0]     outside;
      logic            ovf;
      coord = longint'($signed(item.coordinate));
      w_val = longint'($signed(item.w));
      ovf   = 1'b0;
      if (w_val <= 0) begin
         wide = 32767;
         ovf  = 1'b1;
      end else begin
         w_u = int'(w_val);
         bw  = 0;
         while (bw < 16 && (w_u >> bw) != 0) bw++;
         shift = 15 - bw;
         // top set bit lands on bit 14; 6 index bits and 8 fraction bits below it
         norm  = (w_u << shift) & 32'h3fff;
         idx   = (norm >> 8) & 32'h3f;
         frac  = norm & 32'hff;
         r_lo  = longint'(ptd_pkg::RECIP_ROM[idx]);
         r_hi  = longint'(ptd_pkg::RECIP_ROM[idx + 1]);
         recip = r_lo - (((r_lo - r_hi) * frac + 255) >>> 8);
         product = coord * recip;
         divided = (shift == int'(ptd_pkg::SHIFT_MAX)) ? product * 2
                                                       : product >>> (13 - shift);
         // product bits from 29-shift up to 29 must agree
         mask    = 32'h3fff_ffff & ~((32'd1 << (29 - shift)) - 32'd1);
         outside = product[31:0] & mask;
         if (outside != 32'd0 && outside != mask) begin
            pick = (shift == int'(ptd_pkg::SHIFT_MAX)) ? product : divided;
            ovf  = 1'b1;
            wide = pick[29] ? -32768 : 32767;
         end else begin
            wide = (divided < -65536) ? -65536 : ((divided > 65535) ? 65535 : divided);
         end
      end
      narrow            = (wide < -32768) ? -32768 : ((wide > 32767) ? 32767 : wide);
      res.wide_value    = wide[16:0];
      res.clamped_value = narrow[15:0];
      res.overflow      = ovf;
      return res;
   endfunction

   task automatic flag_mismatch(string field, longint got, longint want);
      if (fail_count < MaxPrinted)
         $display("mismatch on result %0d: %s got %0d, predicted %0d",
                  checked_count, field, got, want);
      fail_count++;
   endtask

   task automatic queue_item(int coord, int w);
      ptd_pkg::ptd_req_type item;
      item.coordinate = coord[15:0];
      item.w          = w[15:0];
      coord_w_q.push_back(item);
   endtask

   // w spread over every bit width, with some non-positive values
   function automatic int random_w();
      int pick;
      int bw;
      pick = $urandom_range(0, 99);
      if (pick < 3) return 0;
      if (pick < 5) return -1;
      if (pick < 7) return -32768;
      if (pick < 10) return -int'($urandom_range(1, 32767));
      bw = $urandom_range(1, 15);
      return (1 << (bw - 1)) | int'($urandom & ((32'd1 << (bw - 1)) - 32'd1));
   endfunction

   function automatic int random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return int'($signed(16'($urandom)));
      if (pick < 85) return int'($urandom_range(0, 512)) - 256;
      if (pick < 92) return 32767 - int'($urandom_range(0, 15));
      return -32768 + int'($urandom_range(0, 15));
   endfunction

   // sender: bursts with gaps, plus a pause for a full drain every few hundred items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            quotient_q.push_back(divide_by_w(req_data));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sent_count % DrainEvery == 0 && sent_count != 0 &&
                         quotient_q.size() != 0) begin
               req_valid <= 1'b0;
            end else if (coord_w_q.size() != 0) begin
               req_data  <= coord_w_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result transaction and stalls on a rotating pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (quotient_q.size() == 0) begin
               flag_mismatch("unexpected transaction", 0, 0);
            end else begin
               ptd_pkg::ptd_rsp_type want;
               want = quotient_q.pop_front();
               if (rsp_data.wide_value !== want.wide_value)
                  flag_mismatch("wide_value", $signed(rsp_data.wide_value),
                                $signed(want.wide_value));
               if (rsp_data.clamped_value !== want.clamped_value)
                  flag_mismatch("clamped_value", $signed(rsp_data.clamped_value),
                                $signed(want.clamped_value));
               if (rsp_data.overflow !== want.overflow)
                  flag_mismatch("overflow", rsp_data.overflow, want.overflow);
            end
            checked_count++;
         end
         rx_cycle++;
         case ((rx_cycle / 97) % 4)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= rx_cycle[2];
            end
         endcase
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      // non-positive w
      queue_item(100, -32768);
      queue_item(-32768, 0);
      queue_item(32767, -1);
      // w of one: product doubled, both saturation signs
      queue_item(32767, 1);
      queue_item(-32768, 1);
      queue_item(5, 1);
      queue_item(-1, 1);
      queue_item(0, 1);
      // extremes of both fields
      queue_item(32767, 32767);
      queue_item(-32768, 32767);
      queue_item(-32768, 16384);
      queue_item(32767, 16384);
      queue_item(1, 32767);
      queue_item(-1, 32767);
      queue_item(0, 32767);
      // small w, saturating in both directions
      queue_item(1000, 2);
      queue_item(-1000, 3);
      queue_item(32767, 2);
      queue_item(-32768, 2);
      // interpolation between table entries
      queue_item(12345, 16'h00ff);
      queue_item(-12345, 16'h0181);
      queue_item(20000, 16'h2001);
      queue_item(-20000, 16'h5555);
      repeat (NumRandom) queue_item(random_coord(), random_w());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (coord_w_q.size() != 0 || req_valid || quotient_q.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0 && quotient_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
